### hdl/bezier_point_eval_defines.svh
// ----------------------------------------------------------------------------
// bezier_point_eval assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_EVAL_DEFINES_SVH
`define BEZIER_POINT_EVAL_DEFINES_SVH

// Same-cycle implication, checked at every rising edge of aclk out of reset
`define BPE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BPE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Types and fixed constants for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int DATA_W    = 32;   // port width of a coordinate
    localparam int IDX_W     = 4;    // point index field
    localparam int PC_W      = 5;    // point count register
    localparam int U_W       = 17;   // curve parameter, Q0.16 plus the one bit
    localparam int FRAC_BITS = 16;

    localparam logic [U_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_DRAIN,
        ST_FETCH,
        ST_DELIVER
    } bpe_state_t;

endpackage

### hdl/bezier_point_eval.sv
`include "bezier_point_eval_defines.svh"
// ----------------------------------------------------------------------------
// bezier_point_eval
// Evaluates a 3D Bezier curve at a parameter u with De Casteljau's scheme in
// Q16.16 fixed point. A write transaction stores one control point (ignored
// at or beyond point_count). An evaluate transaction runs point_count-1
// passes; each pass streams the source store through one read port, one row
// a cycle, and writes (1-u)*a + u*b back to the work store through a
// three-stage subtract, multiply and add pipeline, then waits for that
// pipeline to empty before the next pass reads its results. The evaluation
// time is set by the single read port of the point stores and the pipeline
// drain between passes. A new transaction is accepted while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
module bezier_point_eval
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS  = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  logic [PC_W-1:0]          cfg_wr_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [IDX_W-1:0]         s_point_index,
    input  logic signed [DATA_W-1:0] s_coord_x,
    input  logic signed [DATA_W-1:0] s_coord_y,
    input  logic signed [DATA_W-1:0] s_coord_z,
    input  logic [U_W-1:0]           s_u_param,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_point_x,
    output logic signed [DATA_W-1:0] m_point_y,
    output logic signed [DATA_W-1:0] m_point_z
);

    localparam int CW    = COORD_WIDTH;
    localparam int ROW_W = 3 * CW;
    localparam int PW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_A = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int CMP_W = (CMP_A > PC_W) ? CMP_A : PC_W;
    localparam int PROD_W = CW + 1 + U_W + 1;

    // ---------------------------------------------------------------- state
    bpe_state_t state_reg, state_next;

    logic [CNT_W-1:0] n_eff_reg;
    logic [PW-1:0]    rd_idx_reg, rd_idx_next;
    logic [PW-1:0]    len_reg, len_next;
    logic             first_reg, first_next;
    logic [U_W-1:0]   u_reg, u_next;

    logic             rd_en;
    logic [PW-1:0]    rd_addr;
    logic             ctrl_we;
    logic             out_load;

    logic [ROW_W-1:0] ctrl_mem [MAX_POINTS];
    logic [ROW_W-1:0] work_mem [MAX_POINTS];
    logic [ROW_W-1:0] ctrl_rd_reg;
    logic [ROW_W-1:0] work_rd_reg;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wb_row;
    logic [ROW_W-1:0] ctrl_wr_row;

    logic             rdv_reg;
    logic [PW-1:0]    rd_idx_d_reg;
    logic             dv_reg;
    logic [PW-1:0]    d_addr_reg;
    logic             pv_reg;
    logic [PW-1:0]    p_addr_reg;

    logic signed [CW-1:0]     rd_lane    [3];
    logic signed [CW-1:0]     prev_reg   [3];
    logic signed [CW-1:0]     d_a_reg    [3];
    logic signed [CW:0]       d_diff_reg [3];
    logic signed [CW-1:0]     p_a_reg    [3];
    logic signed [PROD_W-1:0] p_prod_reg [3];
    logic signed [CW+2:0]     wb_sum     [3];

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_point_x_reg;
    logic signed [DATA_W-1:0] m_point_y_reg;
    logic signed [DATA_W-1:0] m_point_z_reg;

    logic [CMP_W-1:0] idx_w;
    logic [CMP_W-1:0] n_w;
    logic [CMP_W-1:0] pc_w;
    logic [CMP_W-1:0] pc_clamped;
    logic [CNT_W-1:0] n_m1;
    logic [U_W-1:0]   u_sat;
    logic             pipe_busy;

    assign idx_w     = CMP_W'(s_point_index);
    assign n_w       = CMP_W'(n_eff_reg);
    assign pc_w      = CMP_W'(cfg_wr_data);
    assign n_m1      = n_eff_reg - CNT_W'(1);
    assign u_sat     = (s_u_param > ONE_Q16) ? ONE_Q16 : s_u_param;
    assign pipe_busy = rdv_reg | dv_reg | pv_reg;

    always_comb begin
        if (pc_w == '0) begin
            pc_clamped = CMP_W'(1);
        end else if (pc_w > CMP_W'(MAX_POINTS)) begin
            pc_clamped = CMP_W'(MAX_POINTS);
        end else begin
            pc_clamped = pc_w;
        end
    end

    assign ctrl_wr_row = {CW'(s_coord_z), CW'(s_coord_y), CW'(s_coord_x)};

    // -------------------------------------------------------- control FSM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            n_eff_reg  <= CNT_W'(1);
            first_reg  <= 1'b1;
            rd_idx_reg <= '0;
            len_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            rd_idx_reg <= rd_idx_next;
            len_reg    <= len_next;
            if (cfg_wr_en) begin
                n_eff_reg <= pc_clamped[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        u_reg <= u_next;
    end

    always_comb begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        len_next    = len_reg;
        first_next  = first_reg;
        u_next      = u_reg;
        s_ready     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg;
        ctrl_we     = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_EVAL) begin
                        u_next      = u_sat;
                        first_next  = 1'b1;
                        rd_idx_next = '0;
                        len_next    = n_m1[PW-1:0];
                        if (n_eff_reg == CNT_W'(1)) begin
                            state_next = ST_FETCH;
                        end else begin
                            state_next = ST_PASS;
                        end
                    end else begin
                        ctrl_we = (idx_w < n_w);
                    end
                end
            end
            ST_PASS: begin
                rd_en = 1'b1;
                if (rd_idx_reg == len_reg) begin
                    rd_idx_next = '0;
                    state_next  = ST_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + PW'(1);
                end
            end
            ST_DRAIN: begin
                // hold until the last write-back of this pass has landed
                if (!pipe_busy) begin
                    first_next = 1'b0;
                    if (len_reg == PW'(1)) begin
                        state_next = ST_FETCH;
                    end else begin
                        len_next   = len_reg - PW'(1);
                        state_next = ST_PASS;
                    end
                end
            end
            ST_FETCH: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------ memories
    always_ff @(posedge aclk) begin
        if (ctrl_we) begin
            ctrl_mem[idx_w[PW-1:0]] <= ctrl_wr_row;
        end
        if (rd_en) begin
            ctrl_rd_reg <= ctrl_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pv_reg) begin
            work_mem[p_addr_reg] <= wb_row;
        end
        if (rd_en) begin
            work_rd_reg <= work_mem[rd_addr];
        end
    end

    // first pass and a one-point curve read the control points directly
    assign rd_row = first_reg ? ctrl_rd_reg : work_rd_reg;

    // ------------------------------------------------ interpolation pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdv_reg <= 1'b0;
            dv_reg  <= 1'b0;
            pv_reg  <= 1'b0;
        end else begin
            rdv_reg <= rd_en;
            dv_reg  <= rdv_reg && (rd_idx_d_reg != '0);
            pv_reg  <= dv_reg;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rd_lane[c] = $signed(rd_row[c*CW +: CW]);
            wb_sum[c]  = $signed(p_prod_reg[c][PROD_W-1:FRAC_BITS])
                       + (CW+3)'(p_a_reg[c]);
            wb_row[c*CW +: CW] = wb_sum[c][CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_d_reg <= rd_addr;
        d_addr_reg   <= rd_idx_d_reg - PW'(1);
        p_addr_reg   <= d_addr_reg;
        for (int c = 0; c < 3; c++) begin
            if (rdv_reg) begin
                prev_reg[c] <= rd_lane[c];
            end
            // a + u*(b - a) equals (1-u)*a + u*b exactly, floor included
            d_a_reg[c]    <= prev_reg[c];
            d_diff_reg[c] <= (CW+1)'(rd_lane[c]) - (CW+1)'(prev_reg[c]);
            p_a_reg[c]    <= d_a_reg[c];
            p_prod_reg[c] <= d_diff_reg[c] * $signed({1'b0, u_reg});
        end
    end

    // -------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_point_x_reg <= DATA_W'(rd_lane[0]);
            m_point_y_reg <= DATA_W'(rd_lane[1]);
            m_point_z_reg <= DATA_W'(rd_lane[2]);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_point_x = m_point_x_reg;
    assign m_point_y = m_point_y_reg;
    assign m_point_z = m_point_z_reg;

    // ------------------------------------------------------------ assertions
    `BPE_ASSERT_IMP(a_busy_blocks_input, (state_reg != ST_IDLE), !s_ready, "input taken while busy")
    `BPE_ASSERT_IMP(a_fetch_after_drain, (state_reg == ST_FETCH), !(dv_reg || pv_reg), "result read before write-back")
    `BPE_ASSERT_IMP(a_wb_in_range, pv_reg, (p_addr_reg < len_reg), "write-back outside pass")
    `BPE_ASSERT_IMP(a_read_in_range, (state_reg == ST_PASS), (rd_idx_reg <= len_reg), "read beyond pass")
    `BPE_ASSERT_NEXT(a_load_from_deliver, out_load, m_valid_reg, "result load lost")

endmodule

### verif/bezier_point_eval_checker.sv
// ----------------------------------------------------------------------------
// bezier_point_eval_checker
// Watches the configuration port and both channels of the Bezier point
// evaluator. Keeps its own copy of the point count and the control points,
// computes the De Casteljau point for every accepted evaluate transaction,
// and compares each accepted result, field by field, against the oldest
// pending point. Hands the number of pending points and failures to the top.
// ----------------------------------------------------------------------------
module bezier_point_eval_checker
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [PC_W-1:0]          cfg_wr_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_operation,
    input  logic [IDX_W-1:0]         s_point_index,
    input  logic signed [DATA_W-1:0] s_coord_x,
    input  logic signed [DATA_W-1:0] s_coord_y,
    input  logic signed [DATA_W-1:0] s_coord_z,
    input  logic [U_W-1:0]           s_u_param,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_point_x,
    input  logic signed [DATA_W-1:0] m_point_y,
    input  logic signed [DATA_W-1:0] m_point_z,
    output int                       points_pending,
    output int                       fail_count
);

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } point_t;

    point_t          ctrl_pts [MAX_POINTS];
    logic [PC_W-1:0] pt_count;
    point_t          curve_q [$];
    int              errs;

    initial begin
        points_pending = 0;
        fail_count     = 0;
        errs           = 0;
        pt_count       = 1;
    end

    function automatic int active_count();
        if (pt_count == 0) return 1;
        if (pt_count > MAX_POINTS) return MAX_POINTS;
        return pt_count;
    endfunction

    // (1-u)*a + u*b in Q16.16, floored by the arithmetic shift
    function automatic logic signed [DATA_W-1:0] blend(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b,
                                                       input logic [U_W-1:0] u);
        longint ua;
        longint va;
        longint acc;
        ua  = u;
        va  = longint'(ONE_Q16) - ua;
        acc = va * longint'(a) + ua * longint'(b);
        return DATA_W'(acc >>> FRAC_BITS);
    endfunction

    function automatic point_t curve_point(input logic [U_W-1:0] u_raw);
        point_t           w [MAX_POINTS];
        logic [U_W-1:0]   u;
        int               n;
        int               k;
        int               i;
        u = (u_raw > ONE_Q16) ? ONE_Q16 : u_raw;
        n = active_count();
        w = ctrl_pts;
        for (k = 0; k < n - 1; k++) begin
            for (i = 0; i < n - 1 - k; i++) begin
                w[i].x = blend(w[i].x, w[i+1].x, u);
                w[i].y = blend(w[i].y, w[i+1].y, u);
                w[i].z = blend(w[i].z, w[i+1].z, u);
            end
        end
        return w[0];
    endfunction

    task automatic check_coord(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        point_t want;
        if (!aresetn) begin
            pt_count = 1;
            curve_q.delete();
        end else begin
            if (cfg_wr_en) pt_count = cfg_wr_data;

            if (m_valid && m_ready) begin
                if (curve_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h",
                             $time, m_point_x, m_point_y, m_point_z);
                    errs++;
                end else begin
                    want = curve_q.pop_front();
                    check_coord("point_x", want.x, m_point_x);
                    check_coord("point_y", want.y, m_point_y);
                    check_coord("point_z", want.z, m_point_z);
                end
            end

            if (s_valid && s_ready) begin
                if (s_operation == OP_EVAL) begin
                    curve_q.push_back(curve_point(s_u_param));
                end else if (s_point_index < active_count()) begin
                    // drop writes beyond the active point count
                    ctrl_pts[s_point_index] = '{x: s_coord_x, y: s_coord_y, z: s_coord_z};
                end
            end
        end
        points_pending <= curve_q.size();
        fail_count     <= errs;
    end

endmodule

### verif/bezier_point_eval_tb.sv
// ----------------------------------------------------------------------------
// bezier_point_eval_tb
// Drives the Bezier point evaluator with a short directed set of control
// points and parameters, then random segments of writes and evaluations
// under changing point counts and three idle patterns on both channels.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bezier_point_eval_tb;
    import bpe_pkg::*;

    localparam int          MAX_PTS         = 16;
    localparam int          QUIET_CYCLES    = 220;
    localparam int          ITEMS_PER_PHASE = 510;
    localparam int unsigned CYCLE_LIMIT     = 2_000_000;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [PC_W-1:0]          cfg_wr_data   = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_operation   = OP_WRITE;
    logic [IDX_W-1:0]         s_point_index = '0;
    logic signed [DATA_W-1:0] s_coord_x     = '0;
    logic signed [DATA_W-1:0] s_coord_y     = '0;
    logic signed [DATA_W-1:0] s_coord_z     = '0;
    logic [U_W-1:0]           s_u_param     = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [DATA_W-1:0] m_point_x;
    logic signed [DATA_W-1:0] m_point_y;
    logic signed [DATA_W-1:0] m_point_z;

    int          points_pending;
    int          fail_count;
    int          tx_idle_pct = 9;
    int          rx_idle_pct = 83;
    int unsigned cycle_count = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bezier_point_eval #(
        .MAX_POINTS  (MAX_PTS),
        .COORD_WIDTH (DATA_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_point_index (s_point_index),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_u_param     (s_u_param),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_z     (m_point_z)
    );

    bezier_point_eval_checker #(
        .MAX_POINTS (MAX_PTS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_point_index  (s_point_index),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .s_coord_z      (s_coord_z),
        .s_u_param      (s_u_param),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_point_z      (m_point_z),
        .points_pending (points_pending),
        .fail_count     (fail_count)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 32'h7FFF_FFFF;
        if (r < 8) return 32'h8000_0000;
        if (r < 10) return '0;
        if (r < 12) return '1;
        if (r < 40) return DATA_W'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
        return $urandom();
    endfunction

    function automatic logic [U_W-1:0] pick_u();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return ONE_Q16;
        if (r < 22) return U_W'($urandom_range(32'h10001, 32'h1FFFF));
        return U_W'($urandom_range(0, 32'h10000));
    endfunction

    // hold valid and payload until the transaction is accepted
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                             input logic [DATA_W-1:0] z, input logic [U_W-1:0] u);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_point_index <= idx;
        s_coord_x     <= x;
        s_coord_y     <= y;
        s_coord_z     <= z;
        s_u_param     <= u;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random();
        send_item($urandom_range(0, 1) ? OP_EVAL : OP_WRITE, IDX_W'($urandom_range(0, 15)),
                  pick_coord(), pick_coord(), pick_coord(), pick_u());
    endtask

    // stop sending, wait for every pending point, then let the inputs stay idle
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (points_pending != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic set_point_count(input logic [PC_W-1:0] count);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int               ph;
        int               seg;
        int               sent;
        int               seg_len;
        int               r;
        int               i;
        logic [PC_W-1:0]  count;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // point count is one out of reset: the curve is point 0
        send_item(OP_WRITE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0);
        send_item(OP_WRITE, 5, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 0);
        send_item(OP_EVAL, 0, 0, 0, 0, 0);
        send_item(OP_EVAL, 0, 0, 0, 0, ONE_Q16);

        // full degree with alternating extremes
        set_point_count(PC_W'(MAX_PTS));
        for (i = 0; i < MAX_PTS; i++) begin
            send_item(OP_WRITE, IDX_W'(i),
                      (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                      (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                      (i % 3 == 0) ? 32'hFFFF_FFFF : pick_coord(), 0);
        end
        send_item(OP_EVAL, 0, 0, 0, 0, 0);
        send_item(OP_EVAL, 0, 0, 0, 0, 1);
        send_item(OP_EVAL, 0, 0, 0, 0, 17'h0FFFF);
        send_item(OP_EVAL, 0, 0, 0, 0, ONE_Q16);
        send_item(OP_EVAL, 0, 0, 0, 0, 17'h1FFFF);

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 9;  rx_idle_pct = 83; end
                1: begin tx_idle_pct = 83; rx_idle_pct = 9;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            sent = 0;
            seg  = 0;
            while (sent < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (ph == 0 && seg == 0) count = 0;
                else if (ph == 0 && seg == 1) count = '1;
                else if (ph == 0 && seg == 2) count = 17;
                else if (ph == 0 && seg == 3) count = 1;
                else if (r < 5) count = PC_W'($urandom_range(17, 31));
                else if (r < 25) count = PC_W'($urandom_range(9, 16));
                else count = PC_W'($urandom_range(1, 8));
                set_point_count(count);
                seg_len = $urandom_range(15, 50);
                repeat (seg_len) send_random();
                sent += seg_len;
                seg++;
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/bpe_pkg.sv
hdl/bezier_point_eval.sv
verif/bezier_point_eval_checker.sv
verif/bezier_point_eval_tb.sv
